FILE: rtl/core/aaht_pkg.sv
// Package for the address alias hash table: request/result types, codes
// and the 64-bit key mix. No dependencies.
`timescale 1ns / 1ps
package aaht_pkg;

  typedef enum logic [1:0] {
    CMD_STORE   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_COMPARE = 2'd2,
    CMD_DRAIN   = 2'd3
  } command_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] address;
    logic [63:0] data_in;
    logic        wide_access;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [63:0] data_out;
    logic [63:0] entry_address;
    logic        entry_wide;
    logic        flagged;
  } result_t;

  // One slot as held in the memory, valid bit included
  typedef struct packed {
    logic        valid;
    logic [63:0] address;
    logic [63:0] value;
    logic        wide;
    logic        deletable;
  } slot_t;

  // 64-bit integer mix, first half (four steps)
  function automatic logic [63:0] mix_a(input logic [63:0] key);
    logic [63:0] k;
    k = key;
    k = k + ~(k << 32);
    k = k ^ (k >> 22);
    k = k + ~(k << 13);
    k = k ^ (k >> 8);
    return k;
  endfunction

  // Second half of the mix
  function automatic logic [63:0] mix_b(input logic [63:0] key);
    logic [63:0] k;
    k = key;
    k = k + (k << 3);
    k = k ^ (k >> 15);
    k = k + ~(k << 27);
    k = k ^ (k >> 31);
    return k;
  endfunction

endpackage

FILE: rtl/core/address_alias_hash_table_unit.sv
// Top level of the address alias hash table: control sequencer and slot
// memory. Depends on aaht_pkg and aaht_mod.
`timescale 1ns / 1ps
// One request at a time. After reset a clearing pass writes every slot
// empty, holding busy high throughout. A store, load or compare with a
// zero address raises the result strobe at the accepting edge itself.
// Any other store, load or compare goes through the second half of the
// key mix, the modulo and its hand-off, then a read and a check of each
// way in turn until a way matches or the last way is checked. A drain
// reads one slot a cycle from slot 0 and raises the strobe on the first
// valid slot it finds, or with a miss when the table is empty. Busy
// drops with the strobe, so the next request may be taken at the
// following edge. The strobe lasts one cycle and the receiver cannot
// stall it.
module address_alias_hash_table_unit #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  aaht_pkg::request_t request,
  output logic               busy,
  output logic               result_valid,
  output aaht_pkg::result_t  result
);
  import aaht_pkg::*;

  localparam int BW    = $clog2(BUCKETS);
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int SW    = $clog2(SLOTS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MIX   = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;

  state_t        state;
  request_t      req;
  logic [63:0]   mixed;
  logic          mod_go, mod_done;
  logic [BW-1:0] bucket, bucket_r;
  logic [WW-1:0] way, free_way, sel_way;
  logic          have_free, free_now;
  logic          cur_match, last_way;
  logic [SW:0]   scan;
  logic [SW-1:0] last_addr;
  logic          pend;

  // Slot memory with a registered read
  slot_t         mem [SLOTS];
  logic [SW-1:0] rd_addr, wr_addr, base, sel_addr;
  logic          wr_en;
  slot_t         wr_data, rd_data;

  aaht_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk(clk), .rst(rst), .go(mod_go), .value(mixed[31:0]),
    .done(mod_done), .bucket(bucket)
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Way check and read address
  always_comb begin
    base      = SW'(bucket_r) * SW'(WAYS);
    cur_match = rd_data.valid && (rd_data.address == req.address);
    last_way  = (way == WW'(WAYS - 1));
    free_now  = have_free || !rd_data.valid;
    sel_way   = cur_match ? way : (have_free ? free_way : way);
    sel_addr  = base + SW'(sel_way);
    if (state == S_DRAIN) rd_addr = scan[SW-1:0];
    else rd_addr = base + SW'(way);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    wr_en        <= 1'b0;
    result_valid <= 1'b0;
    mod_go       <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      scan  <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          // write every slot empty before the first request
          wr_en   <= 1'b1;
          wr_addr <= scan[SW-1:0];
          wr_data <= '0;
          scan    <= scan + 1'b1;
          if (scan == (SW+1)'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          req <= request;
          if (request.command == CMD_DRAIN) begin
            result <= '0;
            scan   <= '0;
            pend   <= 1'b0;
            state  <= S_DRAIN;
          end else if (request.address == 64'd0) begin
            result       <= '{status: ST_ZERO, default: '0};
            result_valid <= 1'b1;
          end else begin
            result <= '0;
            mixed  <= mix_a(request.address);
            state  <= S_MIX;
          end
        end
        S_MIX: begin
          mixed  <= mix_b(mixed);
          mod_go <= 1'b1;
          state  <= S_MOD;
        end
        S_MOD: if (mod_done) begin
          bucket_r  <= bucket;
          way       <= '0;
          have_free <= 1'b0;
          state     <= S_READ;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          // examine the way read last cycle
          if (!rd_data.valid && !have_free) begin
            have_free <= 1'b1;
            free_way  <= way;
          end
          if (cur_match || last_way) begin
            state        <= S_IDLE;
            result_valid <= 1'b1;
            wr_addr      <= sel_addr;
            priority case (req.command)
              CMD_STORE: begin
                if (cur_match || free_now) begin
                  wr_en   <= 1'b1;
                  wr_data <= '{valid: 1'b1, address: req.address,
                              value: req.data_in, wide: req.wide_access,
                              deletable: 1'b0};
                  result.hit        <= cur_match;
                  result.entry_wide <= req.wide_access;
                end else result.status <= ST_FULL;
              end
              default: begin
                if (!cur_match) result.status <= ST_MISS;
                else begin
                  result.hit        <= 1'b1;
                  result.entry_wide <= rd_data.wide;
                  if (req.command == CMD_LOAD) result.data_out <= rd_data.value;
                  else if (rd_data.value == req.data_in) begin
                    wr_en   <= 1'b1;
                    wr_data <= '{valid: 1'b1, address: rd_data.address,
                                value: rd_data.value, wide: rd_data.wide,
                                deletable: 1'b1};
                    result.flagged <= 1'b1;
                  end
                end
              end
            endcase
          end else begin
            way   <= way + 1'b1;
            state <= S_READ;
          end
        end
        S_DRAIN: begin
          // one slot read a cycle, checked the cycle after
          if (pend && rd_data.valid) begin
            wr_en                <= 1'b1;
            wr_addr              <= last_addr;
            wr_data              <= '0;
            result.hit           <= 1'b1;
            result.data_out      <= rd_data.value;
            result.entry_address <= rd_data.address;
            result.entry_wide    <= rd_data.wide;
            result_valid         <= 1'b1;
            state                <= S_IDLE;
          end else if (scan == (SW+1)'(SLOTS)) begin
            result.status <= ST_MISS;
            result_valid  <= 1'b1;
            state         <= S_IDLE;
          end else begin
            pend      <= 1'b1;
            last_addr <= scan[SW-1:0];
            scan      <= scan + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/aaht_mod.sv
// Reduces a 32-bit hash modulo the bucket count by a registered reciprocal
// multiply and a remainder subtract. No package dependency.
`timescale 1ns / 1ps
module aaht_mod #(
  parameter int BUCKETS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] value,
  output logic        done,
  output logic [$clog2(BUCKETS)-1:0] bucket
);

  localparam int BW = $clog2(BUCKETS);
  localparam int SH = 32 + BW;
  // ceil(2^SH / BUCKETS): exact quotient for every 32-bit input
  localparam logic [32:0] RECIP =
    33'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  logic [64:0] prod;
  logic [31:0] val_r;
  logic        step;
  logic [31:0] quot;
  logic [31:0] rem;

  assign quot = 32'(prod >> SH);
  assign rem  = val_r - quot * 32'(BUCKETS);

  // Registers the product with the reciprocal on go, then the remainder into bucket
  always_ff @(posedge clk) begin
    done <= !rst && step;
    if (rst) begin
      step <= 1'b0;
    end else begin
      step <= go;
      if (go) begin
        prod  <= 65'(value) * 65'(RECIP);
        val_r <= value;
      end
      if (step) bucket <= rem[BW-1:0];
    end
  end
endmodule

FILE: bench/tb_address_alias_hash_table_unit.sv
// Testbench for address_alias_hash_table_unit: random and directed requests
// checked against a slot-level predictor. Depends on aaht_pkg and the RTL.
`timescale 1ns / 1ps

// Predicts each result from its own copy of the slot store and checks it
class alias_table_scoreboard;
  localparam int NBUCKETS = 1024;
  localparam int NWAYS    = 4;
  localparam int NSLOTS   = NBUCKETS * NWAYS;

  bit                valid_q  [NSLOTS];
  logic [63:0]       addr_q   [NSLOTS];
  logic [63:0]       value_q  [NSLOTS];
  bit                wide_q   [NSLOTS];
  bit                delete_q [NSLOTS];
  aaht_pkg::result_t expected_results[$];
  int                mismatches;

  function new();
    mismatches = 0;
    foreach (valid_q[i]) valid_q[i] = 0;
  endfunction

  // Wang-style 64-bit mix, low 32 bits reduced modulo the bucket count
  static function int bucket_for(logic [63:0] key);
    logic [63:0] k;
    k = key;
    k += ~(k << 32);
    k ^= (k >> 22);
    k += ~(k << 13);
    k ^= (k >> 8);
    k += (k << 3);
    k ^= (k >> 15);
    k += ~(k << 27);
    k ^= (k >> 31);
    return int'(k[31:0] % NBUCKETS);
  endfunction

  function int find_slot(logic [63:0] key);
    int b;
    b = bucket_for(key);
    for (int w = 0; w < NWAYS; w++)
      if (valid_q[b*NWAYS+w] && addr_q[b*NWAYS+w] == key) return b*NWAYS + w;
    return -1;
  endfunction

  // Stored value for a key, or a random one when absent
  function logic [63:0] value_of(logic [63:0] key);
    int s;
    s = find_slot(key);
    return (s >= 0) ? value_q[s] : {$urandom, $urandom};
  endfunction

  function void note_request(aaht_pkg::request_t req);
    aaht_pkg::result_t r;
    int b, s;
    r = '0;
    if (req.command == aaht_pkg::CMD_DRAIN) begin
      r.status = aaht_pkg::ST_MISS;
      for (int i = 0; i < NSLOTS; i++)
        if (valid_q[i]) begin
          r.status = aaht_pkg::ST_OK;
          r.hit = 1;
          r.data_out = value_q[i];
          r.entry_address = addr_q[i];
          r.entry_wide = wide_q[i];
          valid_q[i] = 0;
          break;
        end
    end else if (req.address == '0) begin
      r.status = aaht_pkg::ST_ZERO;
    end else begin
      b = bucket_for(req.address);
      s = find_slot(req.address);
      if (req.command == aaht_pkg::CMD_STORE) begin
        if (s >= 0) r.hit = 1;
        else
          for (int w = 0; w < NWAYS; w++)
            if (!valid_q[b*NWAYS+w]) begin
              s = b*NWAYS + w;
              break;
            end
        if (s >= 0) begin
          valid_q[s] = 1;
          addr_q[s] = req.address;
          value_q[s] = req.data_in;
          wide_q[s] = req.wide_access;
          delete_q[s] = 0;
          r.entry_wide = req.wide_access;
        end else begin
          r.status = aaht_pkg::ST_FULL;
        end
      end else if (s < 0) begin
        r.status = aaht_pkg::ST_MISS;
      end else begin
        r.hit = 1;
        r.entry_wide = wide_q[s];
        if (req.command == aaht_pkg::CMD_LOAD) r.data_out = value_q[s];
        else if (value_q[s] == req.data_in) begin
          delete_q[s] = 1;
          r.flagged = 1;
        end
      end
    end
    expected_results.push_back(r);
  endfunction

  function void check_result(aaht_pkg::result_t got);
    aaht_pkg::result_t exp;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    exp = expected_results.pop_front();
    if (got.status !== exp.status || got.hit !== exp.hit ||
        got.data_out !== exp.data_out || got.entry_address !== exp.entry_address ||
        got.entry_wide !== exp.entry_wide || got.flagged !== exp.flagged) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, got);
    end
  endfunction
endclass

module tb_address_alias_hash_table_unit;
  import aaht_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  request_t request;
  logic     busy;
  logic     result_valid;
  result_t  result;

  alias_table_scoreboard sb = new();
  logic [63:0] key_pool[$];
  int          idle_pct;

  address_alias_hash_table_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .result_valid(result_valid), .result(result)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Watch both sides of the block
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(request);
      if (result_valid) sb.check_result(result);
    end
  end

  // Offer one request, with an optional gap first, until it is taken
  task automatic issue(command_t cmd, logic [63:0] addr, logic [63:0] data, logic wide);
    request_t r;
    r.command = cmd;
    r.address = addr;
    r.data_in = data;
    r.wide_access = wide;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random key landing in a given bucket
  function automatic logic [63:0] key_in_bucket(int b);
    logic [63:0] k;
    do k = {$urandom, $urandom}; while (k == '0 || sb.bucket_for(k) != b);
    return k;
  endfunction

  task automatic random_request();
    logic [63:0] addr, data;
    int pick;
    pick = $urandom_range(99);
    addr = ($urandom_range(99) < 85) ? key_pool[$urandom_range(key_pool.size()-1)]
                                     : {$urandom, $urandom};
    if ($urandom_range(99) < 2) addr = '0;
    data = {$urandom, $urandom};
    if (pick < 40) issue(CMD_STORE, addr, data, 1'($urandom_range(1)));
    else if (pick < 70) issue(CMD_LOAD, addr, data, 1'($urandom_range(1)));
    else if (pick < 92) begin
      if ($urandom_range(99) < 60) data = sb.value_of(addr);
      issue(CMD_COMPARE, addr, data, 1'($urandom_range(1)));
    end else issue(CMD_DRAIN, {$urandom, $urandom}, data, 1'($urandom_range(1)));
  endtask

  initial begin
    logic [63:0] crowd[5];
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    idle_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty drain, zero address, extremes, a full bucket
    for (int i = 0; i < 5; i++) crowd[i] = key_in_bucket(7);
    issue(CMD_DRAIN, '1, '1, 1'b1);
    issue(CMD_STORE, '0, '1, 1'b1);
    issue(CMD_LOAD, '0, '0, 1'b0);
    issue(CMD_COMPARE, '0, '0, 1'b0);
    issue(CMD_LOAD, '1, '0, 1'b0);
    issue(CMD_STORE, '1, '1, 1'b1);
    issue(CMD_STORE, 64'd1, '0, 1'b0);
    issue(CMD_LOAD, '1, '0, 1'b0);
    issue(CMD_COMPARE, '1, 64'd5, 1'b0);
    issue(CMD_COMPARE, '1, '1, 1'b0);
    issue(CMD_COMPARE, '1, '1, 1'b1);
    issue(CMD_STORE, '1, 64'h1234_5678_9abc_def0, 1'b0);
    for (int i = 0; i < 5; i++) issue(CMD_STORE, crowd[i], {$urandom, $urandom}, i[0]);
    issue(CMD_LOAD, crowd[3], '0, 1'b0);
    issue(CMD_LOAD, crowd[4], '0, 1'b0);
    issue(CMD_COMPARE, 64'd1, '0, 1'b1);
    issue(CMD_DRAIN, '0, '0, 1'b0);
    issue(CMD_DRAIN, '0, '0, 1'b0);

    // Key pool: random keys plus crowded buckets so that stores overflow
    for (int i = 0; i < 48; i++) key_pool.push_back({$urandom, $urandom});
    for (int i = 0; i < 5; i++) key_pool.push_back(crowd[i]);
    for (int i = 0; i < 6; i++) key_pool.push_back(key_in_bucket(900));
    key_pool.push_back('1);

    // Random phases: sender gaps rarely, then often, then never
    idle_pct = 17;
    repeat (550) random_request();
    idle_pct = 57;
    repeat (550) random_request();
    idle_pct = 0;
    repeat (550) random_request();
    start <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/aaht_pkg.sv
rtl/core/aaht_mod.sv
rtl/core/address_alias_hash_table_unit.sv
bench/tb_address_alias_hash_table_unit.sv
